[hw/rtl/lbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_pkg: shared types and helpers for the led blink pattern sequencer
// Register map, operation codes, configuration struct and mode lookups.
// ----------------------------------------------------------------------------
package lbps_pkg;

  localparam int TickPeriodMs = 10;
  localparam int NumModes     = 6;

  localparam int TickW  = 16;
  localparam int ModeW  = 3;
  localparam int MaskW  = 6;
  localparam int CountW = 12;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // operation codes
  localparam logic OpTick    = 1'b0;
  localparam logic OpSetMode = 1'b1;

  // register indexes
  localparam logic [2:0] RegSlowShort = 3'd0;
  localparam logic [2:0] RegSlowLong  = 3'd1;
  localparam logic [2:0] RegFastShort = 3'd2;
  localparam logic [2:0] RegFastLong  = 3'd3;
  localparam logic [2:0] RegFastMask  = 3'd4;
  localparam logic [2:0] RegCounts    = 3'd5;
  localparam logic [2:0] RegRepeat    = 3'd6;

  // reset values
  localparam logic [TickW-1:0]  SlowShortRst = TickW'(250 / TickPeriodMs);
  localparam logic [TickW-1:0]  SlowLongRst  = TickW'(500 / TickPeriodMs);
  localparam logic [TickW-1:0]  FastShortRst = TickW'(50 / TickPeriodMs);
  localparam logic [TickW-1:0]  FastLongRst  = TickW'(100 / TickPeriodMs);
  localparam logic [MaskW-1:0]  FastMaskRst  = 6'd56;
  localparam logic [CountW-1:0] CountsRst    = 12'd3961;
  localparam logic [MaskW-1:0]  RepeatRst    = 6'd7;

  typedef struct packed {
    logic [TickW-1:0]  slow_short;
    logic [TickW-1:0]  slow_long;
    logic [TickW-1:0]  fast_short;
    logic [TickW-1:0]  fast_long;
    logic [MaskW-1:0]  fast_mask;
    logic [CountW-1:0] counts;
    logic [MaskW-1:0]  repeat_mask;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [ModeW-1:0] mode;
  } item_t;

  // modes above the mask width read as zero
  function automatic logic mode_bit(input logic [MaskW-1:0] mask,
                                    input logic [ModeW-1:0] m);
    logic [7:0] ext;
    ext = {2'b00, mask};
    return ext[m];
  endfunction

  function automatic logic [1:0] count_of(input logic [CountW-1:0] counts,
                                          input logic [ModeW-1:0] m);
    logic [15:0] ext;
    ext = {4'b0000, counts};
    return ext[{m, 1'b0} +: 2];
  endfunction

endpackage

[hw/rtl/led_blink_pattern_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_unit: status LED blink sequencer, top level
// Input register, blink state machine with result register, APB registers.
// ----------------------------------------------------------------------------
// Takes one beat per clock (a tick or a mode request) unless the output
// stalls, and returns one result beat per input beat: the beat is registered,
// then one pass of the blink state logic updates the state, which is also the
// result register. in_ready_o drops only while both the input register and the
// result are held by a stalled output. The user must write registers through
// the APB port only while no beat is in flight; the block does not enforce it.
module led_blink_pattern_sequencer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [lbps_pkg::ModeW-1:0] mode_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       led_on_o,
  output logic [lbps_pkg::ModeW-1:0] active_mode_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbps_pkg::AddrW-1:0] paddr,
  input  logic [lbps_pkg::DataW-1:0] pwdata,
  output logic [lbps_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import lbps_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  adv;

  // the held beat moves on when the result slot is free or being taken
  assign adv = item_valid && (!out_valid_o || out_ready_i);

  lbps_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbps_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .mode_i     (mode_i),
    .adv_i      (adv),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  lbps_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .adv_i         (adv),
    .item_i        (item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .led_on_o      (led_on_o),
    .active_mode_o (active_mode_o)
  );

endmodule

[hw/rtl/lbps_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_cfg_regs: configuration register file
// APB-style write and read access to the timing, mask and count registers.
// ----------------------------------------------------------------------------
module lbps_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbps_pkg::AddrW-1:0] paddr,
  input  logic [lbps_pkg::DataW-1:0] pwdata,
  output logic [lbps_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output lbps_pkg::cfg_t             cfg_o
);
  import lbps_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_short  <= SlowShortRst;
      cfg_q.slow_long   <= SlowLongRst;
      cfg_q.fast_short  <= FastShortRst;
      cfg_q.fast_long   <= FastLongRst;
      cfg_q.fast_mask   <= FastMaskRst;
      cfg_q.counts      <= CountsRst;
      cfg_q.repeat_mask <= RepeatRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSlowShort: cfg_q.slow_short  <= pwdata[TickW-1:0];
        RegSlowLong:  cfg_q.slow_long   <= pwdata[TickW-1:0];
        RegFastShort: cfg_q.fast_short  <= pwdata[TickW-1:0];
        RegFastLong:  cfg_q.fast_long   <= pwdata[TickW-1:0];
        RegFastMask:  cfg_q.fast_mask   <= pwdata[MaskW-1:0];
        RegCounts:    cfg_q.counts      <= pwdata[CountW-1:0];
        RegRepeat:    cfg_q.repeat_mask <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSlowShort: prdata = DataW'(cfg_q.slow_short);
      RegSlowLong:  prdata = DataW'(cfg_q.slow_long);
      RegFastShort: prdata = DataW'(cfg_q.fast_short);
      RegFastLong:  prdata = DataW'(cfg_q.fast_long);
      RegFastMask:  prdata = DataW'(cfg_q.fast_mask);
      RegCounts:    prdata = DataW'(cfg_q.counts);
      RegRepeat:    prdata = DataW'(cfg_q.repeat_mask);
      default:      prdata = '0;
    endcase
  end

endmodule

[hw/rtl/lbps_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_in_stage: input register
// Captures one beat and hands it to the sequencer core when it moves on.
// ----------------------------------------------------------------------------
module lbps_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [lbps_pkg::ModeW-1:0] mode_i,
  input  logic                       adv_i,
  output logic                       valid_o,
  output lbps_pkg::item_t            item_o
);
  import lbps_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || adv_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op   <= op_i;
      item_q.mode <= mode_i;
    end
  end

endmodule

[hw/rtl/lbps_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_core: blink state machine and result register
// Applies one mode request or tick per beat; the state doubles as the result.
// ----------------------------------------------------------------------------
module lbps_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbps_pkg::cfg_t             cfg_i,
  input  logic                       adv_i,
  input  lbps_pkg::item_t            item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       led_on_o,
  output logic [lbps_pkg::ModeW-1:0] active_mode_o
);
  import lbps_pkg::*;

  logic [ModeW-1:0] running_q, running_d;
  logic [ModeW-1:0] requested_q, requested_d;
  logic [ModeW-1:0] resting_q, resting_d;
  logic [TickW-1:0] ticks_q, ticks_d;
  logic             phase_q, phase_d;
  logic [1:0]       blinks_q, blinks_d;
  logic             ret_q, ret_d;
  logic             led_q, led_d;
  logic             out_valid_q;

  logic             run_fast;
  logic [TickW-1:0] short_ticks;
  logic [TickW-1:0] long_ticks;
  logic             pat_end;

  assign run_fast    = mode_bit(cfg_i.fast_mask, running_q);
  assign short_ticks = run_fast ? cfg_i.fast_short : cfg_i.slow_short;
  assign long_ticks  = run_fast ? cfg_i.fast_long : cfg_i.slow_long;

  always_comb begin
    running_d   = running_q;
    requested_d = requested_q;
    resting_d   = resting_q;
    ticks_d     = ticks_q;
    phase_d     = phase_q;
    blinks_d    = blinks_q;
    ret_d       = ret_q;
    led_d       = led_q;
    pat_end     = 1'b0;
    if (adv_i) begin
      if (item_i.op == OpSetMode) begin
        // out-of-range requests are dropped
        if ({1'b0, item_i.mode} < (ModeW + 1)'(NumModes)) begin
          requested_d = item_i.mode;
          if (mode_bit(cfg_i.repeat_mask, item_i.mode)) begin
            resting_d = item_i.mode;
          end
        end
      end else begin
        if (ticks_q != '0) begin
          ticks_d = ticks_q - 1'b1;
        end
        if (running_q != requested_q) begin
          // new request cuts the pattern short
          phase_d = 1'b0;
          pat_end = 1'b1;
        end else if (ticks_d == '0) begin
          if (!phase_q) begin
            if (blinks_q >= count_of(cfg_i.counts, running_q)) begin
              pat_end = 1'b1;
            end else begin
              led_d    = 1'b1;
              ticks_d  = short_ticks;
              phase_d  = 1'b1;
              blinks_d = blinks_q + 2'd1;
            end
          end else begin
            led_d   = 1'b0;
            ticks_d = short_ticks;
            phase_d = 1'b0;
          end
        end
        if (pat_end) begin
          led_d     = 1'b0;
          blinks_d  = 2'd0;
          ticks_d   = long_ticks;
          running_d = requested_q;
          if (ret_q) begin
            ret_d       = 1'b0;
            running_d   = resting_q;
            requested_d = resting_q;
          end
          if (!mode_bit(cfg_i.repeat_mask, running_d)) begin
            ret_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      requested_q <= '0;
      resting_q   <= '0;
      ticks_q     <= '0;
      phase_q     <= 1'b0;
      blinks_q    <= 2'd0;
      ret_q       <= 1'b0;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      requested_q <= requested_d;
      resting_q   <= resting_d;
      ticks_q     <= ticks_d;
      phase_q     <= phase_d;
      blinks_q    <= blinks_d;
      ret_q       <= ret_d;
      led_q       <= led_d;
      if (adv_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_on_o      = led_q;
  assign active_mode_o = running_q;

endmodule

[hw/rtl/lbps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_checker: port-level checks for the blink sequencer
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module lbps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       led_on_o,
  input logic [lbps_pkg::ModeW-1:0] active_mode_o,
  input logic                       pready
);
  import lbps_pkg::*;

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(led_on_o)
      && $stable(active_mode_o))
    else $error("result beat changed while stalled");

  // only in-range modes can ever run
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, active_mode_o} < (ModeW + 1)'(NumModes)))
    else $error("active mode out of range");

  // with no result waiting the input side never stalls
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // first edge out of reset shows no result
  a_rst_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // register port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind led_blink_pattern_sequencer_unit lbps_checker u_lbps_checker (.*);

[tb/lbps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbps_tb_checker: result checker for the led blink pattern sequencer
// Follows register writes and input beats on the block's ports, keeps its
// own copy of the blink state, predicts every result beat and compares the
// beats that come back in order. Hands the failure count to the top.
// ----------------------------------------------------------------------------
module lbps_tb_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [lbps_pkg::ModeW-1:0] mode_i,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic                       led_on_o,
  input  logic [lbps_pkg::ModeW-1:0] active_mode_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbps_pkg::AddrW-1:0] paddr,
  input  logic [lbps_pkg::DataW-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         outstanding,
  output int                         results_checked,
  output int                         pattern_ends
);
  import lbps_pkg::*;

  typedef struct packed {
    logic             led;
    logic [ModeW-1:0] mode;
  } shown_t;

  shown_t shown_q[$];
  shown_t shown_now;
  shown_t shown_want;

  cfg_t             cfg;
  logic [ModeW-1:0] run_mode;
  logic [ModeW-1:0] req_mode;
  logic [ModeW-1:0] rest_mode;
  logic [TickW-1:0] ticks_left;
  logic             lit_phase;
  logic [1:0]       blinks_done;
  logic             return_pending;
  logic             led_level;

  // modes past the register bits shift out to zero
  function automatic logic bit_for_mode(input logic [MaskW-1:0] mask,
                                        input logic [ModeW-1:0] m);
    logic [MaskW-1:0] sh;
    sh = mask >> m;
    return sh[0];
  endfunction

  function automatic logic [1:0] blinks_for_mode(input logic [ModeW-1:0] m);
    logic [CountW-1:0] sh;
    sh = cfg.counts >> (2 * m);
    return sh[1:0];
  endfunction

  function automatic logic [TickW-1:0] short_for_mode(input logic [ModeW-1:0] m);
    return bit_for_mode(cfg.fast_mask, m) ? cfg.fast_short : cfg.slow_short;
  endfunction

  function automatic logic [TickW-1:0] long_for_mode(input logic [ModeW-1:0] m);
    return bit_for_mode(cfg.fast_mask, m) ? cfg.fast_long : cfg.slow_long;
  endfunction

  task automatic reset_sequencer();
    cfg.slow_short  = SlowShortRst;
    cfg.slow_long   = SlowLongRst;
    cfg.fast_short  = FastShortRst;
    cfg.fast_long   = FastLongRst;
    cfg.fast_mask   = FastMaskRst;
    cfg.counts      = CountsRst;
    cfg.repeat_mask = RepeatRst;
    run_mode        = '0;
    req_mode        = '0;
    rest_mode       = '0;
    ticks_left      = '0;
    lit_phase       = 1'b0;
    blinks_done     = '0;
    return_pending  = 1'b0;
    led_level       = 1'b1;
  endtask

  task automatic load_register(input logic [2:0] idx, input logic [DataW-1:0] val);
    case (idx)
      RegSlowShort: cfg.slow_short  = val[TickW-1:0];
      RegSlowLong:  cfg.slow_long   = val[TickW-1:0];
      RegFastShort: cfg.fast_short  = val[TickW-1:0];
      RegFastLong:  cfg.fast_long   = val[TickW-1:0];
      RegFastMask:  cfg.fast_mask   = val[MaskW-1:0];
      RegCounts:    cfg.counts      = val[CountW-1:0];
      RegRepeat:    cfg.repeat_mask = val[MaskW-1:0];
      default: ;
    endcase
  endtask

  // long gap starts with the old mode's timing, then the next mode is chosen
  task automatic end_pattern();
    pattern_ends++;
    led_level   = 1'b0;
    blinks_done = '0;
    ticks_left  = long_for_mode(run_mode);
    run_mode    = req_mode;
    if (return_pending) begin
      return_pending = 1'b0;
      run_mode       = rest_mode;
      req_mode       = rest_mode;
    end
    if (!bit_for_mode(cfg.repeat_mask, run_mode)) return_pending = 1'b1;
  endtask

  task automatic advance_tick();
    if (ticks_left != 0) ticks_left--;
    if (run_mode != req_mode) begin
      lit_phase = 1'b0;
      end_pattern();
    end else if (ticks_left == 0) begin
      if (!lit_phase) begin
        if (blinks_done >= blinks_for_mode(run_mode)) begin
          end_pattern();
        end else begin
          led_level   = 1'b1;
          ticks_left  = short_for_mode(run_mode);
          lit_phase   = 1'b1;
          blinks_done = blinks_done + 2'd1;
        end
      end else begin
        led_level  = 1'b0;
        ticks_left = short_for_mode(run_mode);
        lit_phase  = 1'b0;
      end
    end
  endtask

  task automatic request_mode(input logic [ModeW-1:0] m);
    if (m < NumModes) begin
      req_mode = m;
      if (bit_for_mode(cfg.repeat_mask, m)) rest_mode = m;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_sequencer();
      shown_q.delete();
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      pattern_ends    = 0;
    end else begin
      if (psel && penable && pwrite && pready) load_register(paddr[AddrW-1:2], pwdata);

      if (out_valid_o && out_ready_i) begin
        if (shown_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] result beat with nothing pending: led %0b mode %0d",
                     $time, led_on_o, active_mode_o);
        end else begin
          shown_want = shown_q.pop_front();
          results_checked++;
          if (shown_want.led !== led_on_o || shown_want.mode !== active_mode_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] result %0d: expected led %0b mode %0d, got led %0b mode %0d",
                       $time, results_checked, shown_want.led, shown_want.mode,
                       led_on_o, active_mode_o);
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        if (op_i == OpSetMode) request_mode(mode_i);
        else advance_tick();
        shown_now.led  = led_level;
        shown_now.mode = run_mode;
        shown_q.push_back(shown_now);
      end

      outstanding = shown_q.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the led blink pattern sequencer
// Drives ticks and mode requests with bursty timing, stalls the result side,
// reprograms the timing, count and mask registers between phases and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import lbps_pkg::*;

  localparam logic [2:0] RegUnused  = 3'd7;
  localparam int         PhaseCount = 10;

  typedef enum int {ProfZero, ProfMax, ProfRandom} profile_e;
  typedef enum int {ReadyAlways, ReadyCoin, ReadyEvery4, ReadyRare} ready_style_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             op_i        = OpTick;
  logic [ModeW-1:0] mode_i      = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b1;
  logic             led_on_o;
  logic [ModeW-1:0] active_mode_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int fail_count;
  int outstanding;
  int results_checked;
  int pattern_ends;

  int beats_sent;
  int ticks_sent;
  int requests_sent;
  int requests_ignored;
  int settings_used;

  ready_style_e ready_style = ReadyAlways;
  int           ready_left  = 0;
  int           ready_count = 0;

  led_blink_pattern_sequencer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .mode_i        (mode_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .led_on_o      (led_on_o),
    .active_mode_o (active_mode_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lbps_tb_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .mode_i          (mode_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .led_on_o        (led_on_o),
    .active_mode_o   (active_mode_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .pattern_ends    (pattern_ends)
  );

  always #5 clk_i = ~clk_i;

  // result side stalls follow a randomly chosen style, redrawn when its countdown runs out
  always @(negedge clk_i) begin
    ready_count++;
    if (ready_left == 0) begin
      ready_style = ready_style_e'($urandom_range(0, 3));
      ready_left  = $urandom_range(20, 80);
    end else begin
      ready_left--;
    end
    case (ready_style)
      ReadyAlways: out_ready_i <= 1'b1;
      ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
      ReadyEvery4: out_ready_i <= (ready_count % 4 != 0);
      default:     out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input logic op, input logic [ModeW-1:0] m);
    op_i       <= op;
    mode_i     <= m;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
    if (op == OpSetMode) begin
      requests_sent++;
      if (m >= NumModes) requests_ignored++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // leaves psel high; the caller drops it after the last write
  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
  endtask

  // times lean small so that patterns run to their end within a phase
  function automatic logic [DataW-1:0] pick_value(input profile_e prof, input int width);
    int roll;
    roll = $urandom_range(0, 19);
    case (prof)
      ProfZero: return '0;
      ProfMax:  return '1;
      default: begin
        if (width != TickW) return $urandom_range(0, (1 << width) - 1);
        if (roll < 14) return $urandom_range(0, 4);
        if (roll < 19) return $urandom_range(5, 12);
        return $urandom_range(0, 65535);
      end
    endcase
  endfunction

  task automatic program_phase(input profile_e prof, input logic poke_unused);
    apb_write(RegSlowShort, pick_value(prof, TickW));
    apb_write(RegSlowLong,  pick_value(prof, TickW));
    apb_write(RegFastShort, pick_value(prof, TickW));
    apb_write(RegFastLong,  pick_value(prof, TickW));
    apb_write(RegFastMask,  pick_value(prof, MaskW));
    apb_write(RegCounts,    pick_value(prof, CountW));
    apb_write(RegRepeat,    pick_value(prof, MaskW));
    if (poke_unused) apb_write(RegUnused, $urandom);
    psel <= 1'b0;
    settings_used++;
  endtask

  task automatic random_beat();
    logic             op;
    logic [ModeW-1:0] m;
    op = ($urandom_range(0, 6) == 0) ? OpSetMode : OpTick;
    if (op == OpTick) m = ModeW'($urandom_range(0, 7));
    else if ($urandom_range(0, 9) == 0) m = ModeW'($urandom_range(NumModes, 7));
    else m = ModeW'($urandom_range(0, NumModes - 1));
    send_beat(op, m);
  endtask

  initial begin
    item_t    opening[$];
    profile_e prof;
    int       beat_total;
    int       burst_left;
    logic     gaps_on;

    beats_sent       = 0;
    ticks_sent       = 0;
    requests_sent    = 0;
    requests_ignored = 0;
    settings_used    = 1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: ignored requests, one-shot cut short, request while
    // returning to the resting mode, switches between repeating modes
    opening = '{{OpTick, 3'd7}, {OpSetMode, 3'd6}, {OpSetMode, 3'd7}, {OpTick, 3'd0},
                {OpSetMode, 3'd3}, {OpTick, 3'd0}, {OpSetMode, 3'd4}, {OpTick, 3'd1},
                {OpTick, 3'd2}, {OpTick, 3'd4}, {OpTick, 3'd0}, {OpTick, 3'd0},
                {OpSetMode, 3'd1}, {OpSetMode, 3'd2}, {OpTick, 3'd0}, {OpTick, 3'd0},
                {OpTick, 3'd0}, {OpTick, 3'd0}, {OpTick, 3'd0}, {OpTick, 3'd0},
                {OpSetMode, 3'd5}, {OpSetMode, 3'd0}, {OpTick, 3'd0}, {OpTick, 3'd0},
                {OpTick, 3'd0}};
    foreach (opening[i]) send_beat(opening[i].op, opening[i].mode);

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      prof = (p == 0) ? ProfZero : (p == 1) ? ProfMax : ProfRandom;
      program_phase(prof, p == 4);
      beat_total = (prof == ProfMax) ? 60 : (prof == ProfZero) ? 175 : 190;
      gaps_on    = (p % 3 != 1);
      burst_left = 0;
      for (int n = 0; n < beat_total; n++) begin
        if (gaps_on) begin
          if (burst_left == 0) begin
            pause_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
        end
        random_beat();
      end
    end

    drain();
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d beats (%0d ticks, %0d mode requests, %0d out of range)",
             beats_sent, ticks_sent, requests_sent, requests_ignored);
    $display("over %0d register settings; %0d results checked, %0d pattern ends seen",
             settings_used, results_checked, pattern_ends);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", outstanding);
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lbps_pkg.sv
hw/rtl/lbps_cfg_regs.sv
hw/rtl/lbps_in_stage.sv
hw/rtl/lbps_core.sv
hw/rtl/led_blink_pattern_sequencer_unit.sv
hw/rtl/lbps_checker.sv
tb/lbps_checker.sv
tb/testbench.sv
